[hw/rtl/ifp_pkg.sv]
// Shared types and codes for the infix-to-postfix converter.
`timescale 1ns / 1ps
`default_nettype none

package ifp_pkg;

    // Operator stack geometry.
    localparam int STACK_DEPTH = 32;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Input token kinds.
    localparam logic [1:0] KIND_NUMBER   = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    // Operator codes.
    localparam logic [2:0] OP_PLUS   = 3'd0;
    localparam logic [2:0] OP_MINUS  = 3'd1;
    localparam logic [2:0] OP_TIMES  = 3'd2;
    localparam logic [2:0] OP_DIVIDE = 3'd3;
    localparam logic [2:0] OP_POWER  = 3'd4;
    localparam logic [2:0] OP_LPAREN = 3'd5;
    localparam logic [2:0] OP_RPAREN = 3'd6;

    // Result token kinds.
    localparam logic [1:0] TK_NUMBER   = 2'd0;
    localparam logic [1:0] TK_OPERATOR = 2'd1;
    localparam logic [1:0] TK_END      = 2'd2;
    localparam logic [1:0] TK_ERROR    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] number_value;
        logic [2:0]  operator_code;
    } t_in_token;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [31:0] token_number;
        logic [2:0]  token_operator;
        logic        last;
    } t_out_token;

    // Shift command applied to every stack cell at once.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_cmd;

    // Stack status seen by the controller.
    typedef struct packed {
        logic       empty;
        logic       single;
        logic       full;
        logic [2:0] top_op;
    } t_stk_status;

endpackage

`default_nettype wire

[hw/rtl/ifp_cell.sv]
// One cell of the shifting operator stack.
`timescale 1ns / 1ps
`default_nettype none

module ifp_cell
    import ifp_pkg::*;
(
    input  wire logic      i_clk,
    input  t_cell_cmd      i_cmd,
    input  wire logic [2:0] i_from_up,
    input  wire logic [2:0] i_from_down,
    output logic [2:0]     o_op
);

    logic [2:0] r_op;
    logic [2:0] n_op;

    // A push shifts entries away from the top, a pop shifts them toward it.
    always_comb begin
        n_op = r_op;
        if (i_cmd.push) begin
            n_op = i_from_up;
        end else if (i_cmd.pop) begin
            n_op = i_from_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

    assign o_op = r_op;

endmodule

`default_nettype wire

[hw/rtl/ifp_stack.sv]
// Operator stack built as a chain of shifting cells plus an occupancy count.
`timescale 1ns / 1ps
`default_nettype none

module ifp_stack
    import ifp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_cell_cmd       i_cmd,
    input  wire logic       i_clear,
    input  wire logic [2:0] i_push_op,
    output t_stk_status     o_status
);

    logic [2:0]       w_op [STACK_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Cell zero is the top of the stack.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [2:0] w_up;
        logic [2:0] w_down;
        if (g == 0) begin : g_top
            assign w_up = i_push_op;
        end else begin : g_mid
            assign w_up = w_op[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign w_down = w_op[g];
        end else begin : g_inner
            assign w_down = w_op[g+1];
        end
        ifp_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (i_cmd),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_op        (w_op[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_status.empty  = (r_count == '0);
    assign o_status.single = (r_count == CNT_W'(1));
    assign o_status.full   = (r_count >= CNT_W'(STACK_DEPTH));
    assign o_status.top_op = w_op[0];

endmodule

`default_nettype wire

[hw/rtl/infix_to_postfix_converter.sv]
// Top level of the shunting-yard infix-to-postfix converter.
`timescale 1ns / 1ps
`default_nettype none

// The converter takes one token per input transfer (a number, an operator or
// the end of an expression) and produces the postfix token stream on the
// output channel. Numbers pass straight through; operators are held on a
// 32-entry operator stack built as a row of shifting cells, so the top entry
// is always in a fixed register. Plus and minus pop down to a left
// parenthesis, times and divide also stop at plus or minus, power and left
// parenthesis push without popping, and a right parenthesis pops down to its
// matching left one, which is dropped. End of expression drains the stack and
// flags the final result with last; an empty stack gives a lone end marker.
// An unmatched right parenthesis, a leftover left parenthesis at the end, or a
// push onto a full stack yields an error result and empties the stack.
// Token kind 3 and operator code 7 are accepted and ignored. Timing: one
// token is worked on at a time. After a token is accepted, the controller
// performs its stack steps one after another, where a step is one pop (with
// or without a result), the final push, or the single result of a number or
// end marker; each step pops at most one entry, as the cell row has a single
// pop port. Every step, whether or not it produces a result, waits while the
// output register holds a result that is stalled, and the input side is
// stalled while a token is in progress.
module infix_to_postfix_converter
    import ifp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  t_in_token i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out_token o_out_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic        r_state;
    logic        n_state;
    t_in_token   r_tok;
    logic        r_out_valid;
    t_out_token  r_out;

    t_stk_status w_stk;
    t_cell_cmd   w_cmd;
    logic        w_clear;
    logic        w_emit;
    t_out_token  w_res;
    logic        w_done;
    logic        w_can_emit;
    logic        w_in_xfer;
    logic        w_pop_ok;
    logic        w_do_push;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer  = i_in_valid && (r_state == ST_IDLE);

    // A new result may be loaded when the output register is empty or is
    // being drained in this cycle.
    assign w_can_emit = !r_out_valid || !i_out_stall;

    ifp_stack u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_clear   (w_clear),
        .i_push_op (r_tok.operator_code),
        .o_status  (w_stk)
    );

    // One step of the current token per cycle, unless the output register holds a stalled result.
    always_comb begin
        w_cmd     = '0;
        w_clear   = 1'b0;
        w_emit    = 1'b0;
        w_res     = '0;
        w_done    = 1'b0;
        w_pop_ok  = 1'b0;
        w_do_push = 1'b0;

        if ((r_state == ST_WORK) && w_can_emit) begin
            case (r_tok.kind)
                KIND_NUMBER: begin
                    w_emit             = 1'b1;
                    w_res.token_kind   = TK_NUMBER;
                    w_res.token_number = r_tok.number_value;
                    w_done             = 1'b1;
                end
                KIND_END: begin
                    w_emit = 1'b1;
                    if (w_stk.empty) begin
                        w_res.token_kind = TK_END;
                        w_res.last       = 1'b1;
                        w_done           = 1'b1;
                    end else if (w_stk.top_op == OP_LPAREN) begin
                        w_res.token_kind = TK_ERROR;
                        w_res.last       = 1'b1;
                        w_clear          = 1'b1;
                        w_done           = 1'b1;
                    end else begin
                        // Drain one operator; the bottom one closes the item.
                        w_res.token_kind     = TK_OPERATOR;
                        w_res.token_operator = w_stk.top_op;
                        w_res.last           = w_stk.single;
                        w_cmd.pop            = 1'b1;
                        w_done               = w_stk.single;
                    end
                end
                default: begin
                    // Operator token: decide whether the top entry pops.
                    case (r_tok.operator_code)
                        OP_PLUS, OP_MINUS, OP_RPAREN: begin
                            w_pop_ok = !w_stk.empty && (w_stk.top_op != OP_LPAREN);
                        end
                        OP_TIMES, OP_DIVIDE: begin
                            w_pop_ok = !w_stk.empty && (w_stk.top_op != OP_LPAREN)
                                && (w_stk.top_op != OP_PLUS)
                                && (w_stk.top_op != OP_MINUS);
                        end
                        default: begin
                            w_pop_ok = 1'b0;
                        end
                    endcase

                    if (w_pop_ok) begin
                        w_emit               = 1'b1;
                        w_res.token_kind     = TK_OPERATOR;
                        w_res.token_operator = w_stk.top_op;
                        w_cmd.pop            = 1'b1;
                    end else if (r_tok.operator_code == OP_RPAREN) begin
                        w_done = 1'b1;
                        if (w_stk.empty) begin
                            w_emit           = 1'b1;
                            w_res.token_kind = TK_ERROR;
                        end else begin
                            // Matching left parenthesis is dropped silently.
                            w_cmd.pop = 1'b1;
                        end
                    end else begin
                        w_do_push = 1'b1;
                        w_done    = 1'b1;
                    end

                    if (w_do_push) begin
                        if (w_stk.full) begin
                            w_emit           = 1'b1;
                            w_res.token_kind = TK_ERROR;
                            w_clear          = 1'b1;
                        end else begin
                            w_cmd.push = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // Unknown token kinds and operator codes are taken and dropped.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if ((i_in_data.kind == KIND_NUMBER) || (i_in_data.kind == KIND_END)
                        || ((i_in_data.kind == KIND_OPERATOR)
                            && (i_in_data.operator_code <= OP_RPAREN))) begin
                        n_state = ST_WORK;
                    end
                end
            end
            ST_WORK: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_tok <= i_in_data;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
